// ----- hw/rtl/plist_pkg.sv -----
package plist_pkg;

   localparam int CAPACITY_DEFAULT   = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int POSITION_WIDTH = 5;
   localparam int VALUE_WIDTH    = 32;
   localparam int COUNT_WIDTH    = 5;

   localparam int REQ_TDATA_WIDTH = 40;
   localparam int RSP_TDATA_WIDTH = 40;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_REMOVE = 1'b1;

   typedef struct packed {
      logic accept;
      logic take;
      logic latch;
      logic step;
      logic commit;
      logic put;
      logic finish;
   } plist_cmd_type;

   typedef struct packed {
      logic ok;
      logic remove;
      logic moves_zero;
   } plist_status_type;

endpackage

// ----- hw/rtl/plist_ram.sv -----
module plist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/plist_datapath.sv -----
module plist_datapath #(
   parameter int CAPACITY   = plist_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = plist_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  plist_pkg::plist_cmd_type            cmd,
   output plist_pkg::plist_status_type         status,
   input  logic                                req_action,
   input  logic [plist_pkg::POSITION_WIDTH-1:0] req_position,
   input  logic [plist_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic                                rsp_ok,
   output logic [plist_pkg::VALUE_WIDTH-1:0]    rsp_removed_value,
   output logic [plist_pkg::COUNT_WIDTH-1:0]    rsp_entry_count
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int AW   = $clog2(CAPACITY);
   localparam int PW   = plist_pkg::POSITION_WIDTH;
   localparam int VW   = plist_pkg::VALUE_WIDTH;
   localparam int NW   = plist_pkg::COUNT_WIDTH;
   localparam int CMPW = (CW > PW) ? CW : PW;

   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  ok_ff, ok_in;
   logic                  act_ff;
   logic [AW-1:0]         pos_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [CW-1:0]         moves_ff, moves_in;
   logic [AW-1:0]         src_ff, src_in;
   logic [AW-1:0]         dest_ff, dest_in;
   logic [DATA_WIDTH-1:0] taken_ff;
   logic                  rsp_ok_ff;
   logic [VW-1:0]         rsp_removed_ff;
   logic [NW-1:0]         rsp_count_ff;

   logic [CMPW-1:0]       pos_ext, cnt_ext, cap_ext;
   logic [CW-1:0]         cnt_new;
   logic [DATA_WIDTH+VW-1:0] val_wide;
   logic [DATA_WIDTH+VW-1:0] taken_wide;
   logic [CW+NW-1:0]      cnt_wide;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;

   assign pos_ext  = CMPW'(req_position);
   assign cnt_ext  = CMPW'(cnt_ff);
   assign cap_ext  = CMPW'(CAPACITY);
   assign val_wide = {{DATA_WIDTH{1'b0}}, req_value};

   always_comb begin
      if (req_action == plist_pkg::ACTION_REMOVE) begin
         ok_in    = (pos_ext < cnt_ext);
         moves_in = CW'(cnt_ext - pos_ext - CMPW'(1));
         src_in   = AW'(pos_ext + CMPW'(1));
      end else begin
         ok_in    = (pos_ext <= cnt_ext) && (cnt_ext < cap_ext);
         moves_in = CW'(cnt_ext - pos_ext);
         src_in   = AW'(cnt_ext - CMPW'(1));
      end
   end

   always_comb begin
      if (!ok_ff) begin
         cnt_new = cnt_ff;
      end else if (act_ff == plist_pkg::ACTION_REMOVE) begin
         cnt_new = cnt_ff - CW'(1);
      end else begin
         cnt_new = cnt_ff + CW'(1);
      end
   end

   assign cnt_in     = cmd.finish ? cnt_new : cnt_ff;
   assign cnt_wide   = {{NW{1'b0}}, cnt_new};
   assign taken_wide = {{VW{1'b0}}, taken_ff};

   assign dest_in = (act_ff == plist_pkg::ACTION_REMOVE) ? src_ff - AW'(1) : src_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ok_ff    <= ok_in;
         act_ff   <= req_action;
         pos_ff   <= AW'(pos_ext);
         val_ff   <= val_wide[DATA_WIDTH-1:0];
         moves_ff <= moves_in;
         src_ff   <= src_in;
      end else if (cmd.step) begin
         moves_ff <= moves_ff - CW'(1);
         src_ff   <= (act_ff == plist_pkg::ACTION_REMOVE) ? src_ff + AW'(1)
                                                          : src_ff - AW'(1);
         dest_ff  <= dest_in;
      end
      if (cmd.latch) begin
         taken_ff <= rd_data;
      end
      if (cmd.finish) begin
         rsp_ok_ff      <= ok_ff;
         rsp_removed_ff <= (ok_ff && act_ff == plist_pkg::ACTION_REMOVE) ?
                           taken_wide[VW-1:0] : '0;
         rsp_count_ff   <= cnt_wide[NW-1:0];
      end
   end

   assign rd_en   = cmd.take | cmd.step;
   assign rd_addr = cmd.take ? pos_ff : src_ff;
   assign wr_en   = cmd.commit | cmd.put;
   assign wr_addr = cmd.put ? pos_ff : dest_ff;
   assign wr_data = cmd.put ? val_ff : rd_data;

   plist_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign status.ok         = ok_ff;
   assign status.remove     = (act_ff == plist_pkg::ACTION_REMOVE);
   assign status.moves_zero = (moves_ff == '0);

   assign rsp_ok            = rsp_ok_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_entry_count   = rsp_count_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");
`endif

endmodule

// ----- hw/rtl/plist_ctrl.sv -----
module plist_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output plist_pkg::plist_cmd_type    cmd,
   input  plist_pkg::plist_status_type status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_TAKE   = 3'd2;
   localparam logic [2:0] ST_LATCH  = 3'd3;
   localparam logic [2:0] ST_SHIFT  = 3'd4;
   localparam logic [2:0] ST_PUT    = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       pend_ff, pend_in;
   logic       slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      cmd.accept = req_tvalid && req_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (!status.ok) begin
               state_in = ST_DONE;
            end else if (status.remove) begin
               state_in = ST_TAKE;
            end else if (status.moves_zero) begin
               state_in = ST_PUT;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_TAKE: begin
            cmd.take = 1'b1;
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            cmd.latch = 1'b1;
            state_in  = status.moves_zero ? ST_DONE : ST_SHIFT;
         end
         ST_SHIFT: begin
            cmd.step   = !status.moves_zero;
            cmd.commit = pend_ff;
            if (status.moves_zero) begin
               state_in = status.remove ? ST_DONE : ST_PUT;
            end
         end
         ST_PUT: begin
            cmd.put  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pend_in = cmd.step;

   always_comb begin
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat taken while busy");

   a_shift_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && status.moves_zero) |-> pend_ff)
      else $error("shift exit without pending write");

   a_take_latch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAKE) |=> (state_ff == ST_LATCH))
      else $error("removed word not latched");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !cmd.finish)
      else $error("response overwritten while stalled");
`endif

endmodule

// ----- hw/rtl/positional_list_insert_remove.sv -----
// Positional list: an ordered list of up to CAPACITY words with insert and
// remove at a given position.
// Request beats (req_*): tuser is the action (0 insert, 1 remove), tdata
// carries position and value. Response beats (rsp_*): tuser is ok, tdata
// carries the removed word and the entry count after the operation.
// Exactly one response beat follows each request beat, in order.
// One request is worked on at a time; the list RAM moves one entry per cycle
// through its single write port. The entries that move number count -
// position on insert and count - position - 1 on remove. A refused request
// goes straight to the response; an insert shifts those entries up and then
// writes the new word; a remove reads and latches the word at the position,
// then shifts the entries above it down. req_tready rises at the same edge
// that raises rsp_tvalid.
// The response sits in an output register; the next request is taken while
// it waits, but its own response holds back until the receiver takes the
// previous beat. A stalled receiver therefore stalls the block after one
// further request.
// Reset empties the list (count to zero), drops any pending response and
// holds req_tready low; the RAM contents are not cleared and are read only
// once written.
module positional_list_insert_remove #(
   parameter int CAPACITY   = plist_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = plist_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // position [4:0], value [36:5], zero [39:37]
   input  logic [plist_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // action [0]
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // removed_value [31:0], entry_count [36:32], zero [39:37]
   output logic [plist_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // ok [0]
   output logic                                 rsp_tuser
);

   localparam int PW = plist_pkg::POSITION_WIDTH;
   localparam int VW = plist_pkg::VALUE_WIDTH;
   localparam int NW = plist_pkg::COUNT_WIDTH;

   plist_pkg::plist_cmd_type    cmd;
   plist_pkg::plist_status_type status;

   logic [VW-1:0] rsp_removed_value;
   logic [NW-1:0] rsp_entry_count;

   plist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd),
      .status    (status)
   );

   plist_datapath #(
      .CAPACITY  (CAPACITY),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_tuser),
      .req_position     (req_tdata[PW-1:0]),
      .req_value        (req_tdata[PW+VW-1:PW]),
      .rsp_ok           (rsp_tuser),
      .rsp_removed_value(rsp_removed_value),
      .rsp_entry_count  (rsp_entry_count)
   );

   assign rsp_tdata = {{(plist_pkg::RSP_TDATA_WIDTH - VW - NW){1'b0}},
                       rsp_entry_count, rsp_removed_value};

endmodule

// ----- test/plist_checker.sv -----
module plist_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   input  logic                                   req_tready,
   // position [4:0], value [36:5], zero [39:37]
   input  logic [plist_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   // action [0]
   input  logic                                   req_tuser,
   input  logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // removed_value [31:0], entry_count [36:32], zero [39:37]
   input  logic [plist_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   // ok [0]
   input  logic                                   rsp_tuser,
   output int                                     mismatches,
   output int                                     outstanding,
   output logic [plist_pkg::COUNT_WIDTH-1:0]      list_count
);

   localparam int CAPACITY  = plist_pkg::CAPACITY_DEFAULT;
   localparam int POS_W     = plist_pkg::POSITION_WIDTH;
   localparam int VAL_W     = plist_pkg::VALUE_WIDTH;
   localparam int CNT_W     = plist_pkg::COUNT_WIDTH;
   localparam int PAD_W     = plist_pkg::RSP_TDATA_WIDTH - VAL_W - CNT_W;

   typedef struct packed {
      logic             ok;
      logic [VAL_W-1:0] removed;
      logic [CNT_W-1:0] count;
   } list_response_type;

   logic [VAL_W-1:0]  words [CAPACITY];
   logic [CNT_W-1:0]  held = '0;
   list_response_type pending_responses [$];
   list_response_type want;
   int                errors = 0;

   initial begin
      mismatches  = 0;
      outstanding = 0;
      list_count  = '0;
   end

   function automatic list_response_type apply_request(input logic action,
                                                       input logic [POS_W-1:0] pos,
                                                       input logic [VAL_W-1:0] value);
      list_response_type rsp;
      int i;
      rsp = '0;
      if (action == plist_pkg::ACTION_INSERT) begin
         if (pos <= held && held < CAPACITY) begin
            for (i = held; i > pos; i--) words[i] = words[i-1];
            words[pos] = value;
            held = held + 1'b1;
            rsp.ok = 1'b1;
         end
      end else if (pos < held) begin
         rsp.removed = words[pos];
         for (i = pos; i + 1 < held; i++) words[i] = words[i+1];
         held = held - 1'b1;
         rsp.ok = 1'b1;
      end
      rsp.count = held;
      return rsp;
   endfunction

   task automatic check_field(input string name, input logic [VAL_W-1:0] expected,
                              input logic [VAL_W-1:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0h, got %0h", name, expected, actual);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held = '0;
         pending_responses.delete();
      end else begin
         if (req_tvalid && req_tready)
            pending_responses.push_back(apply_request(req_tuser, req_tdata[POS_W-1:0],
                                                      req_tdata[POS_W +: VAL_W]));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_responses.size() == 0) begin
               $error("response beat with no request outstanding");
               errors++;
            end else begin
               want = pending_responses.pop_front();
               check_field("ok", VAL_W'(want.ok), VAL_W'(rsp_tuser));
               check_field("removed_value", want.removed, rsp_tdata[VAL_W-1:0]);
               check_field("entry_count", VAL_W'(want.count), VAL_W'(rsp_tdata[VAL_W +: CNT_W]));
               check_field("padding", '0, VAL_W'(rsp_tdata[VAL_W + CNT_W +: PAD_W]));
            end
         end
      end
      mismatches  <= errors;
      outstanding <= pending_responses.size();
      list_count  <= held;
   end

endmodule

// ----- test/tb_positional_list_insert_remove.sv -----
module tb_positional_list_insert_remove;

   localparam int POS_W        = plist_pkg::POSITION_WIDTH;
   localparam int VAL_W        = plist_pkg::VALUE_WIDTH;
   localparam int CAPACITY     = plist_pkg::CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 1200;
   localparam int TAIL_START   = RANDOM_ITEMS - 150;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_tvalid = 1'b0;
   logic                                   req_tready;
   logic [plist_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata = '0;
   logic                                   req_tuser = 1'b0;
   logic                                   rsp_tvalid;
   logic                                   rsp_tready = 1'b0;
   logic [plist_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata;
   logic                                   rsp_tuser;

   int                                     mismatches;
   int                                     outstanding;
   logic [plist_pkg::COUNT_WIDTH-1:0]      list_count;

   logic                                   sender_idles = 1'b0;
   logic                                   receiver_idles = 1'b0;
   int                                     stall_left = 0;
   int                                     cycles = 0;

   always #5 clock = ~clock;

   positional_list_insert_remove i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   plist_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .list_count  (list_count)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL positional_list_insert_remove");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || !receiver_idles) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // hold the beat until it is taken, then maybe drop valid for a burst
   task automatic send_request(input logic action, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {{(plist_pkg::REQ_TDATA_WIDTH - POS_W - VAL_W){1'b0}}, value, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   function automatic logic [POS_W-1:0] pick_position(input logic action);
      int fill;
      logic [POS_W-1:0] pos;
      fill = int'(list_count);
      if ($urandom_range(0, 9) == 0)
         pos = POS_W'($urandom_range(0, CAPACITY));
      else if (action == plist_pkg::ACTION_INSERT)
         pos = POS_W'($urandom_range(0, fill));
      else if (fill == 0)
         pos = '0;
      else
         pos = POS_W'($urandom_range(0, fill - 1));
      return pos;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      logic [VAL_W-1:0] value;
      case ($urandom_range(0, 7))
         0: value = '0;
         1: value = '1;
         2: value = VAL_W'(1) << $urandom_range(0, VAL_W - 1);
         default: value = $urandom;
      endcase
      return value;
   endfunction

   initial begin
      int sent;
      int len;
      int mode;
      logic action;
      sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      sender_idles = 1'b1;
      receiver_idles <= 1'b1;

      send_request(plist_pkg::ACTION_REMOVE, POS_W'(0), 32'h1234_5678);
      send_request(plist_pkg::ACTION_INSERT, POS_W'(1), 32'hDEAD_BEEF);
      send_request(plist_pkg::ACTION_INSERT, POS_W'(0), 32'h0000_0000);
      send_request(plist_pkg::ACTION_INSERT, POS_W'(1), 32'hFFFF_FFFF);
      send_request(plist_pkg::ACTION_INSERT, POS_W'(0), 32'hA5A5_A5A5);
      send_request(plist_pkg::ACTION_INSERT, POS_W'(1), 32'h5A5A_5A5A);
      send_request(plist_pkg::ACTION_REMOVE, POS_W'(4), 32'hFFFF_FFFF);
      send_request(plist_pkg::ACTION_REMOVE, POS_W'(3), 32'h0000_0000);
      send_request(plist_pkg::ACTION_REMOVE, POS_W'(0), 32'h0000_0000);
      for (int k = 2; k < CAPACITY; k++)
         send_request(plist_pkg::ACTION_INSERT, k[POS_W-1:0], $urandom);
      send_request(plist_pkg::ACTION_INSERT, POS_W'(16), 32'hCAFE_F00D);
      send_request(plist_pkg::ACTION_INSERT, POS_W'(3), 32'h0BAD_CAFE);
      send_request(plist_pkg::ACTION_REMOVE, POS_W'(16), 32'hFFFF_FFFF);
      send_request(plist_pkg::ACTION_REMOVE, POS_W'(15), 32'h0000_0000);
      send_request(plist_pkg::ACTION_REMOVE, POS_W'(0), 32'h0000_0000);

      while (sent < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 2);
         len  = $urandom_range(8, 60);
         if (sent < TAIL_START) begin
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_idles <= ($urandom_range(0, 3) != 0);
         end
         for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
            // drop all idling in the tail
            if (sent >= TAIL_START) begin
               sender_idles = 1'b0;
               receiver_idles <= 1'b0;
            end
            case (mode)
               0: action = ($urandom_range(0, 9) < 8) ? plist_pkg::ACTION_INSERT
                                                      : plist_pkg::ACTION_REMOVE;
               1: action = ($urandom_range(0, 9) < 8) ? plist_pkg::ACTION_REMOVE
                                                      : plist_pkg::ACTION_INSERT;
               default: action = $urandom_range(0, 1) ? plist_pkg::ACTION_REMOVE
                                                      : plist_pkg::ACTION_INSERT;
            endcase
            send_request(action, pick_position(action), pick_value());
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS positional_list_insert_remove");
      else
         $display("FAIL positional_list_insert_remove");
      $finish;
   end

endmodule
